[design/cbb_pkg.sv]
`default_nettype none

package cbb_pkg;

  localparam int NUM_COLORS     = 4;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int PIX_W      = 16;
  localparam int IN_TDATA_W = 16;
  localparam int SIZE_W     = 11;
  localparam int BOX_W      = 11;
  localparam int CNT_W      = 21;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int COLOR_W    = 2;

  localparam int OUT_FIELDS_W = 1 + 4 * BOX_W + CNT_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_ANY_BIT  = OUT_FIELDS_W - 1;

  localparam int RST_FRAME_WIDTH  = 320;
  localparam int RST_FRAME_HEIGHT = 240;
  localparam int RST_MIN_COUNT    = 300;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [9:0] RED_MIN      = 10'd150;
  localparam logic [9:0] RED_MARGIN   = 10'd40;
  localparam logic [9:0] GRN_MIN      = 10'd120;
  localparam logic [9:0] GRN_MARGIN   = 10'd20;
  localparam logic [9:0] BLU_MIN      = 10'd120;
  localparam logic [9:0] BLU_MARGIN_R = 10'd20;
  localparam logic [9:0] BLU_MARGIN_G = 10'd10;
  localparam logic [9:0] YEL_R_MIN    = 10'd140;
  localparam logic [9:0] YEL_G_MIN    = 10'd110;
  localparam logic [9:0] YEL_B_MAX    = 10'd100;

  typedef enum logic [COLOR_W-1:0] {
    COLOR_RED    = 2'd0,
    COLOR_GREEN  = 2'd1,
    COLOR_BLUE   = 2'd2,
    COLOR_YELLOW = 2'd3
  } color_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MIN_COUNT    = 2'd2
  } cfg_idx_t;

endpackage

`default_nettype wire

[design/cbb_classify.sv]
`default_nettype none

module cbb_classify (
  input  logic [cbb_pkg::PIX_W-1:0]      pixel_word,
  output logic [cbb_pkg::NUM_COLORS-1:0] match
);
  import cbb_pkg::*;

  logic [PIX_W-1:0] px;
  logic [9:0]       r;
  logic [9:0]       g;
  logic [9:0]       b;

  always_comb begin
    px = {pixel_word[7:0], pixel_word[15:8]};
    r  = {2'b00, px[15:11], 3'b000};
    g  = {2'b00, px[10:5], 2'b00};
    b  = {2'b00, px[4:0], 3'b000};

    match[COLOR_RED]    = (r > RED_MIN) && (r > g + RED_MARGIN) && (r > b + RED_MARGIN);
    match[COLOR_GREEN]  = (g > GRN_MIN) && (g > r + GRN_MARGIN) && (g > b + GRN_MARGIN);
    match[COLOR_BLUE]   = (b > BLU_MIN) && (b > r + BLU_MARGIN_R) && (b > g + BLU_MARGIN_G);
    match[COLOR_YELLOW] = (r > YEL_R_MIN) && (g > YEL_G_MIN) && (b < YEL_B_MAX);
  end

endmodule

`default_nettype wire

[design/cbb_tracker.sv]
`default_nettype none

module cbb_tracker #(
  parameter int XW = 10,
  parameter int YW = 10
) (
  input  logic                       clk,
  input  logic                       clr,
  input  logic                       upd,
  input  logic [XW-1:0]              x,
  input  logic [YW-1:0]              y,
  input  logic [XW:0]                w_eff,
  input  logic [YW:0]                h_eff,
  output logic [XW:0]                snap_left,
  output logic [YW:0]                snap_top,
  output logic signed [XW:0]         snap_right,
  output logic signed [YW:0]         snap_bottom,
  output logic [cbb_pkg::CNT_W-1:0]  snap_cnt
);
  import cbb_pkg::*;

  logic [XW:0]        left_r,   left_nxt;
  logic [YW:0]        top_r,    top_nxt;
  logic signed [XW:0] right_r,  right_nxt;
  logic signed [YW:0] bottom_r, bottom_nxt;
  logic [CNT_W-1:0]   cnt_r,    cnt_nxt;

  logic [XW:0] xe;
  logic [YW:0] ye;

  always_comb begin
    xe = {1'b0, x};
    ye = {1'b0, y};

    snap_left   = (upd && (xe < left_r)) ? xe : left_r;
    snap_top    = (upd && (ye < top_r)) ? ye : top_r;
    snap_right  = (upd && ($signed(xe) > right_r)) ? $signed(xe) : right_r;
    snap_bottom = (upd && ($signed(ye) > bottom_r)) ? $signed(ye) : bottom_r;
    snap_cnt    = (upd && (cnt_r != CNT_MAX)) ? cnt_r + 1'b1 : cnt_r;

    if (clr) begin
      left_nxt   = w_eff;
      top_nxt    = h_eff;
      right_nxt  = '1;
      bottom_nxt = '1;
      cnt_nxt    = '0;
    end else begin
      left_nxt   = snap_left;
      top_nxt    = snap_top;
      right_nxt  = snap_right;
      bottom_nxt = snap_bottom;
      cnt_nxt    = snap_cnt;
    end
  end

  always_ff @(posedge clk) begin
    left_r   <= left_nxt;
    top_r    <= top_nxt;
    right_r  <= right_nxt;
    bottom_r <= bottom_nxt;
    cnt_r    <= cnt_nxt;
  end

endmodule

`default_nettype wire

[design/cbb_out.sv]
`default_nettype none

module cbb_out #(
  parameter int XW = 10,
  parameter int YW = 10
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          snap,
  input  logic [cbb_pkg::NUM_COLORS-1:0][XW:0]          snap_left,
  input  logic [cbb_pkg::NUM_COLORS-1:0][YW:0]          snap_top,
  input  logic [cbb_pkg::NUM_COLORS-1:0][XW:0]          snap_right,
  input  logic [cbb_pkg::NUM_COLORS-1:0][YW:0]          snap_bottom,
  input  logic [cbb_pkg::NUM_COLORS-1:0][cbb_pkg::CNT_W-1:0] snap_cnt,
  input  logic [cbb_pkg::CNT_W-1:0]                     min_cnt,
  output logic                                          bank_busy,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  output logic [cbb_pkg::OUT_TDATA_W-1:0]               out_tdata,
  output logic [cbb_pkg::COLOR_W-1:0]                   out_tuser,
  output logic                                          out_tlast
);
  import cbb_pkg::*;

  localparam int REM_W = $clog2(NUM_COLORS + 1);

  logic [NUM_COLORS-1:0][XW:0]      bk_left_r;
  logic [NUM_COLORS-1:0][YW:0]      bk_top_r;
  logic [NUM_COLORS-1:0][XW:0]      bk_right_r;
  logic [NUM_COLORS-1:0][YW:0]      bk_bottom_r;
  logic [NUM_COLORS-1:0][CNT_W-1:0] bk_cnt_r;

  logic [REM_W-1:0] rem_r;
  color_t           idx_r;
  logic             any_r;
  logic             ov_r;

  color_t           o_color_r;
  logic             o_det_r;
  logic [BOX_W-1:0] o_left_r;
  logic [BOX_W-1:0] o_top_r;
  logic [BOX_W-1:0] o_right_r;
  logic [BOX_W-1:0] o_bottom_r;
  logic [CNT_W-1:0] o_cnt_r;
  logic             o_any_r;
  logic             o_last_r;

  logic               load;
  logic [XW:0]        sel_left;
  logic [YW:0]        sel_top;
  logic signed [XW:0] sel_right;
  logic signed [YW:0] sel_bottom;
  logic [CNT_W-1:0]   sel_cnt;
  logic               det;
  logic               is_last;

  always_comb begin
    bank_busy  = (rem_r != '0);
    load       = bank_busy && (!ov_r || out_tready);
    sel_left   = bk_left_r[idx_r];
    sel_top    = bk_top_r[idx_r];
    sel_right  = $signed(bk_right_r[idx_r]);
    sel_bottom = $signed(bk_bottom_r[idx_r]);
    sel_cnt    = bk_cnt_r[idx_r];
    det        = (sel_cnt > min_cnt)
              && ($signed({sel_right[XW], sel_right}) > $signed({1'b0, sel_left}))
              && ($signed({sel_bottom[YW], sel_bottom}) > $signed({1'b0, sel_top}));
    is_last    = (idx_r == COLOR_YELLOW);
  end

  always_ff @(posedge clk) begin
    if (snap) begin
      bk_left_r   <= snap_left;
      bk_top_r    <= snap_top;
      bk_right_r  <= snap_right;
      bk_bottom_r <= snap_bottom;
      bk_cnt_r    <= snap_cnt;
    end
    if (load) begin
      o_color_r  <= idx_r;
      o_det_r    <= det;
      o_left_r   <= BOX_W'(sel_left);
      o_top_r    <= BOX_W'(sel_top);
      o_right_r  <= BOX_W'(sel_right);
      o_bottom_r <= BOX_W'(sel_bottom);
      o_cnt_r    <= sel_cnt;
      o_any_r    <= is_last && (any_r || det);
      o_last_r   <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      idx_r <= COLOR_RED;
      any_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      if (snap) begin
        rem_r <= REM_W'(NUM_COLORS);
        idx_r <= COLOR_RED;
        any_r <= 1'b0;
      end else if (load) begin
        rem_r <= rem_r - 1'b1;
        idx_r <= color_t'(idx_r + 1'b1);
        if (det) begin
          any_r <= 1'b1;
        end
      end
      ov_r <= load || (ov_r && !out_tready);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = o_color_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, o_any_r, o_cnt_r, o_bottom_r,
                       o_right_r, o_top_r, o_left_r, o_det_r};

endmodule

`default_nettype wire

[design/color_blob_bounding_box.sv]
`default_nettype none

// Channel  Ports               Beat contents
// in       in_t*               tdata: pixel_word[15:0]
// out      out_t*              tuser: color_index; tlast: last_result;
//                              tdata: see the port comment
// cfg      cfg_wr_en/index     0 frame_width, 1 frame_height, 2 min_pixel_count
//
// One pixel is accepted every cycle unless the input stalls. A pixel that ends a frame waits
// in the input register while the four results of the previous frame still sit in the result
// bank, which drains one beat per cycle while out_tready is high, so frames shorter than
// five pixels stall the input. Results leave the result bank through an output register.
// Reset is synchronous and active low; it loads 320 x 240 and a minimum count of 300.

module color_blob_bounding_box #(
  parameter int MAX_WIDTH  = cbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pixel_word
  input  logic [cbb_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // detected, box_left, box_top, box_right, box_bottom, match_count, any_detected, zero pad
  output logic [cbb_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // color_index
  output logic [cbb_pkg::COLOR_W-1:0]       out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_wr_en,
  input  logic [cbb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import cbb_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int XBW = XW + 1;
  localparam int YBW = YW + 1;
  localparam int RST_W_EFF = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
  localparam int RST_H_EFF = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;

  logic [XBW-1:0]   w_eff_r,   w_eff_nxt;
  logic [YBW-1:0]   h_eff_r,   h_eff_nxt;
  logic [CNT_W-1:0] min_cnt_r, min_cnt_nxt;

  logic [XW-1:0] col_r;
  logic [YW-1:0] line_r;

  logic                  s1_valid_r;
  logic [NUM_COLORS-1:0] s1_match_r;
  logic [XW-1:0]         s1_x_r;
  logic [YW-1:0]         s1_y_r;
  logic                  s1_eof_r;

  logic             wr_w;
  logic             wr_h;
  logic             wr_min;
  logic [SIZE_W-1:0] size_val;
  logic [XBW-1:0]   w_clamp;
  logic [YBW-1:0]   h_clamp;

  logic [NUM_COLORS-1:0] in_match;
  logic                  bank_busy;
  logic                  s1_adv;
  logic                  in_acc;
  logic                  col_last;
  logic                  line_last;
  logic                  frame_end;
  logic                  trk_clr;

  logic [NUM_COLORS-1:0][XBW-1:0]   snap_left;
  logic [NUM_COLORS-1:0][YBW-1:0]   snap_top;
  logic [NUM_COLORS-1:0][XBW-1:0]   snap_right;
  logic [NUM_COLORS-1:0][YBW-1:0]   snap_bottom;
  logic [NUM_COLORS-1:0][CNT_W-1:0] snap_cnt;

  always_comb begin
    wr_w   = 1'b0;
    wr_h   = 1'b0;
    wr_min = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  wr_w   = 1'b1;
        CFG_FRAME_HEIGHT: wr_h   = 1'b1;
        CFG_MIN_COUNT:    wr_min = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    size_val = cfg_wdata[SIZE_W-1:0];
    if (size_val == '0) begin
      w_clamp = XBW'(1);
      h_clamp = YBW'(1);
    end else begin
      w_clamp = (int'(size_val) > MAX_WIDTH) ? XBW'(MAX_WIDTH) : XBW'(size_val);
      h_clamp = (int'(size_val) > MAX_HEIGHT) ? YBW'(MAX_HEIGHT) : YBW'(size_val);
    end

    if (!rst_n) begin
      w_eff_nxt   = XBW'(RST_W_EFF);
      h_eff_nxt   = YBW'(RST_H_EFF);
      min_cnt_nxt = CNT_W'(RST_MIN_COUNT);
    end else begin
      w_eff_nxt   = wr_w ? w_clamp : w_eff_r;
      h_eff_nxt   = wr_h ? h_clamp : h_eff_r;
      min_cnt_nxt = wr_min ? cfg_wdata[CNT_W-1:0] : min_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    w_eff_r   <= w_eff_nxt;
    h_eff_r   <= h_eff_nxt;
    min_cnt_r <= min_cnt_nxt;
  end

  cbb_classify u_classify (
    .pixel_word (in_tdata[PIX_W-1:0]),
    .match      (in_match)
  );

  always_comb begin
    s1_adv    = s1_valid_r && !(s1_eof_r && bank_busy);
    in_tready = !s1_valid_r || s1_adv;
    in_acc    = in_tvalid && in_tready;
    col_last  = (({1'b0, col_r} + XBW'(1)) == w_eff_r);
    line_last = (({1'b0, line_r} + YBW'(1)) == h_eff_r);
    frame_end = s1_adv && s1_eof_r;
    trk_clr   = !rst_n || wr_w || wr_h || frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      col_r      <= '0;
      line_r     <= '0;
    end else begin
      if (wr_w || wr_h) begin
        col_r  <= '0;
        line_r <= '0;
      end else if (in_acc) begin
        col_r <= col_last ? '0 : col_r + 1'b1;
        if (col_last) begin
          line_r <= line_last ? '0 : line_r + 1'b1;
        end
      end
      s1_valid_r <= in_acc || (s1_valid_r && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_match_r <= in_match;
      s1_x_r     <= col_r;
      s1_y_r     <= line_r;
      s1_eof_r   <= col_last && line_last;
    end
  end

  for (genvar k = 0; k < NUM_COLORS; k++) begin : g_trk
    cbb_tracker #(
      .XW (XW),
      .YW (YW)
    ) u_tracker (
      .clk         (clk),
      .clr         (trk_clr),
      .upd         (s1_adv && s1_match_r[k]),
      .x           (s1_x_r),
      .y           (s1_y_r),
      .w_eff       (w_eff_nxt),
      .h_eff       (h_eff_nxt),
      .snap_left   (snap_left[k]),
      .snap_top    (snap_top[k]),
      .snap_right  (snap_right[k]),
      .snap_bottom (snap_bottom[k]),
      .snap_cnt    (snap_cnt[k])
    );
  end

  cbb_out #(
    .XW (XW),
    .YW (YW)
  ) u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .snap        (frame_end),
    .snap_left   (snap_left),
    .snap_top    (snap_top),
    .snap_right  (snap_right),
    .snap_bottom (snap_bottom),
    .snap_cnt    (snap_cnt),
    .min_cnt     (min_cnt_r),
    .bank_busy   (bank_busy),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

`ifndef NO_ASSERTIONS
  a_snap_free: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |-> !bank_busy)
    else $error("frame closed while the result bank was still occupied");

  a_last_yellow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == COLOR_YELLOW)
    else $error("last result of a frame is not the yellow result");

  a_any_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tdata[OUT_ANY_BIT])
    else $error("any_detected set before the last result");

  a_bank_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> bank_busy)
    else $error("result bank not loaded after the end of a frame");
`endif

endmodule

`default_nettype wire

[sim/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbb_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int PARTIAL_PIXELS = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {FLOW_FREE, SEND_GAPS, RECV_STALLS, BOTH_IDLE} idle_mode_t;

  typedef struct packed {
    color_t           color;
    logic             detected;
    logic [BOX_W-1:0] left;
    logic [BOX_W-1:0] top;
    logic [BOX_W-1:0] right;
    logic [BOX_W-1:0] bottom;
    logic [CNT_W-1:0] count;
    logic             any_hit;
    logic             last;
  } box_result_t;

  class frame_box_board;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [CNT_W-1:0]  min_count_reg;
    int col;
    int row;
    int left_b[NUM_COLORS];
    int top_b[NUM_COLORS];
    int right_b[NUM_COLORS];
    int bottom_b[NUM_COLORS];
    int hits[NUM_COLORS];
    box_result_t expected_boxes[$];
    int failures;
    int pixels;
    int frames;
    int beats;

    function new();
      width_reg = SIZE_W'(RST_FRAME_WIDTH);
      height_reg = SIZE_W'(RST_FRAME_HEIGHT);
      min_count_reg = CNT_W'(RST_MIN_COUNT);
      failures = 0;
      pixels = 0;
      frames = 0;
      beats = 0;
      restart_frame();
    endfunction

    function int clamp_size(int v, int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function void restart_frame();
      col = 0;
      row = 0;
      for (int k = 0; k < NUM_COLORS; k++) begin
        left_b[k] = clamp_size(int'(width_reg), DEF_MAX_WIDTH);
        top_b[k] = clamp_size(int'(height_reg), DEF_MAX_HEIGHT);
        right_b[k] = -1;
        bottom_b[k] = -1;
        hits[k] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FRAME_WIDTH: begin
          width_reg = val[SIZE_W-1:0];
          restart_frame();
        end
        CFG_FRAME_HEIGHT: begin
          height_reg = val[SIZE_W-1:0];
          restart_frame();
        end
        CFG_MIN_COUNT: min_count_reg = val[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit color_hit(int k, int r, int g, int b);
      case (k)
        COLOR_RED:
          return r > int'(RED_MIN) && r > g + int'(RED_MARGIN) && r > b + int'(RED_MARGIN);
        COLOR_GREEN:
          return g > int'(GRN_MIN) && g > r + int'(GRN_MARGIN) && g > b + int'(GRN_MARGIN);
        COLOR_BLUE:
          return b > int'(BLU_MIN) && b > r + int'(BLU_MARGIN_R) && b > g + int'(BLU_MARGIN_G);
        default:
          return r > int'(YEL_R_MIN) && g > int'(YEL_G_MIN) && b < int'(YEL_B_MAX);
      endcase
    endfunction

    function void track_pixel(logic [PIX_W-1:0] raw);
      logic [15:0] px;
      int r;
      int g;
      int b;
      int w;
      int h;
      bit any;
      bit det;
      box_result_t res;
      px = {raw[7:0], raw[15:8]};
      r = int'(px[15:11]) * 8;
      g = int'(px[10:5]) * 4;
      b = int'(px[4:0]) * 8;
      w = clamp_size(int'(width_reg), DEF_MAX_WIDTH);
      h = clamp_size(int'(height_reg), DEF_MAX_HEIGHT);
      pixels++;
      for (int k = 0; k < NUM_COLORS; k++) begin
        if (color_hit(k, r, g, b)) begin
          if (col < left_b[k]) left_b[k] = col;
          if (row < top_b[k]) top_b[k] = row;
          if (col > right_b[k]) right_b[k] = col;
          if (row > bottom_b[k]) bottom_b[k] = row;
          if (hits[k] < int'(CNT_MAX)) hits[k]++;
        end
      end
      if (col + 1 < w) begin
        col++;
        return;
      end
      col = 0;
      if (row + 1 < h) begin
        row++;
        return;
      end
      frames++;
      any = 0;
      for (int k = 0; k < NUM_COLORS; k++) begin
        det = hits[k] > int'(min_count_reg) && right_b[k] > left_b[k] &&
              bottom_b[k] > top_b[k];
        any |= det;
        res.color = color_t'(k);
        res.detected = det;
        res.left = BOX_W'(left_b[k]);
        res.top = BOX_W'(top_b[k]);
        res.right = BOX_W'(right_b[k]);
        res.bottom = BOX_W'(bottom_b[k]);
        res.count = CNT_W'(hits[k]);
        res.any_hit = (k == NUM_COLORS - 1) && any;
        res.last = (k == NUM_COLORS - 1);
        expected_boxes.push_back(res);
      end
      restart_frame();
    endfunction

    function string box_text(box_result_t v);
      return $sformatf("color %0d det %0b box (%0d,%0d)-(%0d,%0d) count %0d any %0b last %0b",
                       v.color, v.detected, v.left, v.top, $signed(v.right),
                       $signed(v.bottom), v.count, v.any_hit, v.last);
    endfunction

    function void compare_box(logic [COLOR_W-1:0] user, logic last,
                              logic [OUT_TDATA_W-1:0] data);
      box_result_t want;
      box_result_t got;
      beats++;
      got.color = color_t'(user);
      got.detected = data[0];
      got.left = data[1 +: BOX_W];
      got.top = data[1 + BOX_W +: BOX_W];
      got.right = data[1 + 2 * BOX_W +: BOX_W];
      got.bottom = data[1 + 3 * BOX_W +: BOX_W];
      got.count = data[1 + 4 * BOX_W +: CNT_W];
      got.any_hit = data[OUT_ANY_BIT];
      got.last = last;
      if (expected_boxes.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("Result beat with nothing expected: %s", box_text(got));
        return;
      end
      want = expected_boxes.pop_front();
      if (want !== got) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("Mismatch: expected %s, got %s", box_text(want), box_text(got));
      end
    endfunction

    function int pending();
      return expected_boxes.size();
    endfunction

    function void flush_leftovers();
      if (expected_boxes.size() > 0) begin
        failures += expected_boxes.size();
        $display("%0d expected result beats never arrived", expected_boxes.size());
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [COLOR_W-1:0]     out_tuser;
  logic                   out_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;
  frame_box_board board;

  color_blob_bounding_box DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.compare_box(out_tuser, out_tlast, out_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [PIX_W-1:0] pixel_of(int r5, int g6, int b5);
    logic [15:0] px;
    px = {r5[4:0], g6[5:0], b5[4:0]};
    return {px[7:0], px[15:8]};
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0, 1, 2: return PIX_W'($urandom);
      3: return pixel_of($urandom_range(18, 31), $urandom_range(0, 40), $urandom_range(0, 20));
      4: return pixel_of($urandom_range(0, 15), $urandom_range(29, 63), $urandom_range(0, 15));
      5: return pixel_of($urandom_range(0, 15), $urandom_range(0, 30), $urandom_range(14, 31));
      6: return pixel_of($urandom_range(17, 31), $urandom_range(26, 63), $urandom_range(0, 13));
      7: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return pixel_of($urandom_range(16, 20), $urandom_range(26, 32),
                               $urandom_range(11, 17));
    endcase
  endfunction

  task automatic set_mode(idle_mode_t mode);
    case (mode)
      FLOW_FREE: begin
        send_idle = 0;
        recv_stall = 0;
      end
      SEND_GAPS: begin
        send_idle = 64;
        recv_stall = 0;
      end
      RECV_STALLS: begin
        send_idle = 0;
        recv_stall = 64;
      end
      default: begin
        send_idle = 35;
        recv_stall = 35;
      end
    endcase
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] raw);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = raw;
    do @(posedge clk); while (!in_tready);
    board.track_pixel(raw);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic hold_for_results();
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_frames(int w, int h, int min_cnt, int nframes, idle_mode_t mode);
    int npix;
    settle();
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_MIN_COUNT, CFG_DATA_W'(min_cnt));
    set_mode(mode);
    npix = board.clamp_size(w, DEF_MAX_WIDTH) * board.clamp_size(h, DEF_MAX_HEIGHT);
    for (int f = 0; f < nframes; f++) begin
      for (int p = 0; p < npix; p++) send_pixel(random_pixel());
      if (f == 0 || $urandom_range(0, 5) == 0) hold_for_results();
    end
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Single-pixel frames: each color alone, the raw extremes, and the red threshold.
    set_mode(FLOW_FREE);
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(1));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(1));
    write_reg(CFG_MIN_COUNT, CFG_DATA_W'(0));
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    send_pixel(pixel_of(31, 0, 0));
    send_pixel(pixel_of(0, 63, 0));
    send_pixel(pixel_of(0, 0, 31));
    send_pixel(pixel_of(31, 63, 0));
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(pixel_of(19, 0, 0));
    send_pixel(pixel_of(18, 0, 0));

    // A 2x2 frame with red on the diagonal gives a box with real extent.
    settle();
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(2));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(2));
    send_pixel(pixel_of(31, 0, 0));
    send_pixel(16'h0000);
    send_pixel(16'h0000);
    send_pixel(pixel_of(31, 0, 0));

    // A size write discards a partial frame; a count write or a spare index does not.
    send_pixel(pixel_of(31, 63, 0));
    send_pixel(pixel_of(0, 0, 31));
    send_pixel(pixel_of(31, 0, 0));
    settle();
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(2));
    send_pixel(pixel_of(0, 63, 0));
    send_pixel(pixel_of(0, 63, 0));
    settle();
    write_reg(CFG_MIN_COUNT, CFG_DATA_W'(1));
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    send_pixel(pixel_of(0, 63, 0));
    send_pixel(pixel_of(0, 63, 0));

    run_frames(3, 2, 0, 6, FLOW_FREE);
    run_frames(4, 3, 1, 4, SEND_GAPS);
    run_frames(0, 5, 2, 8, RECV_STALLS);
    run_frames(5, 0, 0, 8, BOTH_IDLE);

    // Oversized sizes are clamped; the partial frame is dropped by the next size write.
    settle();
    set_mode(FLOW_FREE);
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(2047));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(2047));
    write_reg(CFG_MIN_COUNT, CFG_DATA_W'(CNT_MAX));
    for (int p = 0; p < PARTIAL_PIXELS; p++) send_pixel(random_pixel());

    run_frames(8, 4, 3, 1, BOTH_IDLE);
    run_frames($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(0, 4), 3, SEND_GAPS);
    run_frames(6, 6, 1048576, 1, RECV_STALLS);

    settle();
    board.flush_leftovers();
    $display("Covered %0d pixels in %0d frames, sizes from 1x1 to 8x6 plus oversized sizes.",
             board.pixels, board.frames);
    $display("Compared %0d result beats under four idle patterns; %0d failures.",
             board.beats, board.failures);
    if (board.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
